// File: rtl/core/cep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cep_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned MinCntW  = 16;
  localparam int unsigned BusErrW  = 16;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [TimeW-1:0]   TIMEOUT_DEFAULT   = 32'd50;
  localparam logic [MinCntW-1:0] MIN_COUNT_DEFAULT = 16'd16;
  localparam logic [LenW-1:0]    PROBE_LENGTH      = 4'd8;

  localparam logic [CmdW-1:0] CMD_PROBE = 2'd0;
  localparam logic [CmdW-1:0] CMD_FRAME = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_MIN_CNT  = 2'd1;
  localparam logic [1:0] REG_TX_ID    = 2'd2;
  localparam logic [1:0] REG_ECHO_ID  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PROBE   = 3'd1,
    KIND_FRAME   = 3'd2,
    KIND_BAD_LEN = 3'd3,
    KIND_TICK    = 3'd4
  } kind_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_RUNNING = 3'd0,
    VERDICT_OK      = 3'd1,
    VERDICT_SILENT  = 3'd2,
    VERDICT_CORRUPT = 3'd3,
    VERDICT_LOSSY   = 3'd4,
    VERDICT_DROPPED = 3'd5
  } verdict_e;

  typedef struct packed {
    logic [TimeW-1:0]   tmo_limit;
    logic [MinCntW-1:0] min_count;
    logic [IdW-1:0]     echo_id;
  } cfg_t;

  // one classified transaction as it sits in the queue
  typedef struct packed {
    kind_e              kind;
    logic [SeqW-1:0]    seq;
    logic               pat_ok;
    logic [TimeW-1:0]   now_ms;
    logic [TimeW-1:0]   rtt_us;
    logic [BusErrW-1:0] bus_err;
  } item_t;

  typedef struct packed {
    logic                accepted;
    logic                probe_valid;
    logic [PayloadW-1:0] probe_payload;
    verdict_e            verdict;
    logic [CountW-1:0]   sent;
    logic [CountW-1:0]   echoed;
    logic [CountW-1:0]   corrupt;
    logic [CountW-1:0]   stale;
    logic [CountW-1:0]   timeouts;
    logic [TimeW-1:0]    rtt_min;
    logic [TimeW-1:0]    rtt_max;
  } result_t;

  function automatic logic [7:0] pattern_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'hFF;
      2'd2:    b = 8'h55;
      2'd3:    b = 8'hAA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [PayloadW-1:0] make_payload(input logic [SeqW-1:0] seq);
    logic [7:0] b;
    b = pattern_byte(seq[1:0]);
    return {b, b, b, b, b, b, seq};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cep_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module cep_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cep_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [cep_pkg::ApbDataW-1:0]  pwdata,
  output logic      [cep_pkg::ApbDataW-1:0]  prdata,
  output cep_pkg::cfg_t                      cfg_o
);

  logic [cep_pkg::TimeW-1:0]   timeout_q,  timeout_d;
  logic [cep_pkg::MinCntW-1:0] min_cnt_q,  min_cnt_d;
  logic [cep_pkg::IdW-1:0]     tx_id_q,    tx_id_d;
  logic [cep_pkg::IdW-1:0]     echo_id_q,  echo_id_d;
  logic                        wr_en;
  logic [1:0]                  reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    timeout_d  = timeout_q;
    min_cnt_d  = min_cnt_q;
    tx_id_d    = tx_id_q;
    echo_id_d  = echo_id_q;
    if (wr_en) begin
      case (reg_sel)
        cep_pkg::REG_TIMEOUT: begin
          timeout_d = (pwdata == '0) ? cep_pkg::TIMEOUT_DEFAULT : pwdata;
        end
        cep_pkg::REG_MIN_CNT:  min_cnt_d  = pwdata[cep_pkg::MinCntW-1:0];
        cep_pkg::REG_TX_ID:    tx_id_d    = pwdata[cep_pkg::IdW-1:0];
        cep_pkg::REG_ECHO_ID:  echo_id_d  = pwdata[cep_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= cep_pkg::TIMEOUT_DEFAULT;
      min_cnt_q  <= cep_pkg::MIN_COUNT_DEFAULT;
      tx_id_q    <= '0;
      echo_id_q  <= '0;
    end else begin
      timeout_q  <= timeout_d;
      min_cnt_q  <= min_cnt_d;
      tx_id_q    <= tx_id_d;
      echo_id_q  <= echo_id_d;
    end
  end

  always_comb begin
    case (reg_sel)
      cep_pkg::REG_TIMEOUT:  prdata = timeout_q;
      cep_pkg::REG_MIN_CNT:  prdata = {{(cep_pkg::ApbDataW-cep_pkg::MinCntW){1'b0}}, min_cnt_q};
      cep_pkg::REG_TX_ID:    prdata = {{(cep_pkg::ApbDataW-cep_pkg::IdW){1'b0}}, tx_id_q};
      cep_pkg::REG_ECHO_ID:  prdata = {{(cep_pkg::ApbDataW-cep_pkg::IdW){1'b0}}, echo_id_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.tmo_limit  = timeout_q;
  assign cfg_o.min_count  = min_cnt_q;
  assign cfg_o.echo_id    = echo_id_q;

endmodule

`default_nettype wire

// File: rtl/core/cep_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cep_front (
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [cep_pkg::CmdW-1:0]        cmd_i,
  input  wire logic [cep_pkg::TimeW-1:0]       now_ms_i,
  input  wire logic [cep_pkg::IdW-1:0]         rx_identifier_i,
  input  wire logic [cep_pkg::LenW-1:0]        rx_length_i,
  input  wire logic [cep_pkg::PayloadW-1:0]    rx_payload_i,
  input  wire logic [cep_pkg::TimeW-1:0]       round_trip_us_i,
  input  wire logic [cep_pkg::BusErrW-1:0]     bus_error_count_i,
  input  wire cep_pkg::cfg_t                   cfg_i,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output cep_pkg::item_t                       q_item_o
);

  cep_pkg::kind_e kind;

  always_comb begin
    case (cmd_i)
      cep_pkg::CMD_PROBE: kind = cep_pkg::KIND_PROBE;
      cep_pkg::CMD_FRAME: begin
        // frames with a foreign identifier are dropped here and only report
        if (rx_identifier_i != cfg_i.echo_id) begin
          kind = cep_pkg::KIND_NONE;
        end else if (rx_length_i != cep_pkg::PROBE_LENGTH) begin
          kind = cep_pkg::KIND_BAD_LEN;
        end else begin
          kind = cep_pkg::KIND_FRAME;
        end
      end
      cep_pkg::CMD_TICK:  kind = cep_pkg::KIND_TICK;
      default:            kind = cep_pkg::KIND_NONE;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign q_item_o.kind    = kind;
  assign q_item_o.seq     = rx_payload_i[cep_pkg::SeqW-1:0];
  // payload check against the frame's own sequence; back side compares that to the awaited one
  assign q_item_o.pat_ok  =
    (rx_payload_i == cep_pkg::make_payload(rx_payload_i[cep_pkg::SeqW-1:0]));
  assign q_item_o.now_ms  = now_ms_i;
  assign q_item_o.rtt_us  = round_trip_us_i;
  assign q_item_o.bus_err = bus_error_count_i;

endmodule

`default_nettype wire

// File: rtl/core/cep_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cep_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cep_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output cep_pkg::item_t      item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cep_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q,  count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cep_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cep_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cep_pkg::cfg_t  cfg_i,
  input  wire logic           q_valid_i,
  input  wire cep_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cep_pkg::result_t    result_o
);

  logic [cep_pkg::SeqW-1:0]   next_seq_q,  next_seq_d;
  logic [cep_pkg::SeqW-1:0]   awaited_q,   awaited_d;
  logic                       in_flight_q, in_flight_d;
  logic [cep_pkg::TimeW-1:0]  send_time_q, send_time_d;
  logic [cep_pkg::CountW-1:0] sent_q,    sent_d;
  logic [cep_pkg::CountW-1:0] echoed_q,  echoed_d;
  logic [cep_pkg::CountW-1:0] corrupt_q, corrupt_d;
  logic [cep_pkg::CountW-1:0] stale_q,   stale_d;
  logic [cep_pkg::CountW-1:0] tmo_q,     tmo_d;
  logic [cep_pkg::TimeW-1:0]  rtt_min_q, rtt_min_d;
  logic [cep_pkg::TimeW-1:0]  rtt_max_q, rtt_max_d;
  logic [cep_pkg::TimeW-1:0]  elapsed;
  logic                       out_valid_q;
  cep_pkg::result_t           res_q, res_d;
  logic                       load;

  assign load    = !out_valid_q || !out_stall_i;
  assign q_pop_o = q_valid_i && load;
  assign elapsed = q_item_i.now_ms - send_time_q;

  always_comb begin
    next_seq_d  = next_seq_q;
    awaited_d   = awaited_q;
    in_flight_d = in_flight_q;
    send_time_d = send_time_q;
    sent_d      = sent_q;
    echoed_d    = echoed_q;
    corrupt_d   = corrupt_q;
    stale_d     = stale_q;
    tmo_d       = tmo_q;
    rtt_min_d   = rtt_min_q;
    rtt_max_d   = rtt_max_q;
    res_d       = '0;

    case (q_item_i.kind)
      cep_pkg::KIND_PROBE: begin
        if (!in_flight_q) begin
          res_d.accepted      = 1'b1;
          res_d.probe_valid   = 1'b1;
          res_d.probe_payload = cep_pkg::make_payload(next_seq_q);
          awaited_d   = next_seq_q;
          in_flight_d = 1'b1;
          send_time_d = q_item_i.now_ms;
          sent_d      = sent_q + 1'b1;
          next_seq_d  = next_seq_q + 1'b1;
        end
      end
      cep_pkg::KIND_BAD_LEN: begin
        res_d.accepted = 1'b1;
        corrupt_d      = corrupt_q + 1'b1;
        in_flight_d    = 1'b0;
      end
      cep_pkg::KIND_FRAME: begin
        res_d.accepted = 1'b1;
        if (!in_flight_q || (q_item_i.seq != awaited_q)) begin
          stale_d = stale_q + 1'b1;
        end else begin
          if (!q_item_i.pat_ok) begin
            corrupt_d = corrupt_q + 1'b1;
          end else begin
            echoed_d = echoed_q + 1'b1;
            // first echo after reset or after the counter wraps loads the minimum
            if ((echoed_d == cep_pkg::CountW'(1)) || (q_item_i.rtt_us < rtt_min_q)) begin
              rtt_min_d = q_item_i.rtt_us;
            end
            if (q_item_i.rtt_us > rtt_max_q) begin
              rtt_max_d = q_item_i.rtt_us;
            end
          end
          in_flight_d = 1'b0;
        end
      end
      cep_pkg::KIND_TICK: begin
        if (in_flight_q && (elapsed >= cfg_i.tmo_limit)) begin
          res_d.accepted = 1'b1;
          in_flight_d    = 1'b0;
          tmo_d          = tmo_q + 1'b1;
        end
      end
      default: ;
    endcase

    // verdict is taken from the counts after this transaction
    if (sent_d < {{(cep_pkg::CountW-cep_pkg::MinCntW){1'b0}}, cfg_i.min_count}) begin
      res_d.verdict = cep_pkg::VERDICT_RUNNING;
    end else if ((echoed_d == '0) && (corrupt_d == '0) && (stale_d == '0)) begin
      res_d.verdict = cep_pkg::VERDICT_SILENT;
    end else if (corrupt_d != '0) begin
      res_d.verdict = cep_pkg::VERDICT_CORRUPT;
    end else if ((tmo_d != '0) || (stale_d != '0)) begin
      res_d.verdict = (q_item_i.bus_err == '0) ? cep_pkg::VERDICT_DROPPED
                                               : cep_pkg::VERDICT_LOSSY;
    end else begin
      res_d.verdict = cep_pkg::VERDICT_OK;
    end

    res_d.sent     = sent_d;
    res_d.echoed   = echoed_d;
    res_d.corrupt  = corrupt_d;
    res_d.stale    = stale_d;
    res_d.timeouts = tmo_d;
    res_d.rtt_min  = rtt_min_d;
    res_d.rtt_max  = rtt_max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q  <= '0;
      awaited_q   <= '0;
      in_flight_q <= 1'b0;
      send_time_q <= '0;
      sent_q      <= '0;
      echoed_q    <= '0;
      corrupt_q   <= '0;
      stale_q     <= '0;
      tmo_q       <= '0;
      rtt_min_q   <= '0;
      rtt_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        next_seq_q  <= next_seq_d;
        awaited_q   <= awaited_d;
        in_flight_q <= in_flight_d;
        send_time_q <= send_time_d;
        sent_q      <= sent_d;
        echoed_q    <= echoed_d;
        corrupt_q   <= corrupt_d;
        stale_q     <= stale_d;
        tmo_q       <= tmo_d;
        rtt_min_q   <= rtt_min_d;
        rtt_max_q   <= rtt_max_d;
      end
      if (load) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// File: rtl/core/can_echo_probe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Echo probe checker for a bus link, one probe outstanding at a time. The input
// channel takes a transaction every cycle while the queue is not full: a front
// stage classifies it (command, echo identifier, length, payload pattern) into a
// QueueDepth-entry queue, and a back stage applies it to the probe state and
// counters and registers one result per transaction. Sustained rate is one
// transaction per clock while the output is not stalled; while a result is
// stalled the back stage takes nothing and the queue goes on taking transactions
// until it is full. Registers sit on the APB port at byte offsets 0x0 timeout
// (ms, zero writes 50), 0x4 minimum probe count, 0x8 probe identifier,
// 0xC echo identifier; write them only while no transaction is in progress.
module can_echo_probe_checker #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cep_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [cep_pkg::ApbDataW-1:0]  pwdata,
  output logic      [cep_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cep_pkg::CmdW-1:0]      cmd_i,
  input  wire logic [cep_pkg::TimeW-1:0]     now_ms_i,
  input  wire logic [cep_pkg::IdW-1:0]       rx_identifier_i,
  input  wire logic [cep_pkg::LenW-1:0]      rx_length_i,
  input  wire logic [cep_pkg::PayloadW-1:0]  rx_payload_i,
  input  wire logic [cep_pkg::TimeW-1:0]     round_trip_us_i,
  input  wire logic [cep_pkg::BusErrW-1:0]   bus_error_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic                               probe_valid_o,
  output logic      [cep_pkg::PayloadW-1:0]  probe_payload_o,
  output logic      [cep_pkg::VerdictW-1:0]  verdict_o,
  output logic      [cep_pkg::CountW-1:0]    sent_total_o,
  output logic      [cep_pkg::CountW-1:0]    echoed_total_o,
  output logic      [cep_pkg::CountW-1:0]    corrupt_total_o,
  output logic      [cep_pkg::CountW-1:0]    stale_total_o,
  output logic      [cep_pkg::CountW-1:0]    timeout_total_o,
  output logic      [cep_pkg::TimeW-1:0]     rtt_low_us_o,
  output logic      [cep_pkg::TimeW-1:0]     rtt_high_us_o
);

  cep_pkg::cfg_t    cfg;
  cep_pkg::item_t   push_item, head_item;
  cep_pkg::result_t result;
  logic             q_push, q_full, q_pop, q_valid;

  assign pready = 1'b1;

  cep_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  cep_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .now_ms_i          (now_ms_i),
    .rx_identifier_i   (rx_identifier_i),
    .rx_length_i       (rx_length_i),
    .rx_payload_i      (rx_payload_i),
    .round_trip_us_i   (round_trip_us_i),
    .bus_error_count_i (bus_error_count_i),
    .cfg_i             (cfg),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_item_o          (push_item)
  );

  cep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  cep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign accepted_o      = result.accepted;
  assign probe_valid_o   = result.probe_valid;
  assign probe_payload_o = result.probe_payload;
  assign verdict_o       = result.verdict;
  assign sent_total_o    = result.sent;
  assign echoed_total_o  = result.echoed;
  assign corrupt_total_o = result.corrupt;
  assign stale_total_o   = result.stale;
  assign timeout_total_o = result.timeouts;
  assign rtt_low_us_o    = result.rtt_min;
  assign rtt_high_us_o   = result.rtt_max;

endmodule

`default_nettype wire

// File: rtl/core/cep_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cep_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          accepted_o,
  input wire logic                          probe_valid_o,
  input wire logic [cep_pkg::PayloadW-1:0]  probe_payload_o,
  input wire logic [cep_pkg::CountW-1:0]    sent_total_o
);

  // a probe going out must have been taken
  a_probe_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && probe_valid_o) |-> accepted_o)
    else $error("probe payload without accepted");

  // no probe means an all-zero payload
  a_idle_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !probe_valid_o) |-> (probe_payload_o == '0))
    else $error("payload not cleared without probe");

  // the probe carries the sequence matching the sent count before it
  a_probe_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && probe_valid_o) |->
      (probe_payload_o[cep_pkg::SeqW-1:0] ==
       cep_pkg::SeqW'(sent_total_o - cep_pkg::CountW'(1))))
    else $error("probe sequence does not follow sent count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sent_total_o)))
    else $error("stalled result changed");

endmodule

bind can_echo_probe_checker cep_checker u_cep_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .accepted_o      (accepted_o),
  .probe_valid_o   (probe_valid_o),
  .probe_payload_o (probe_payload_o),
  .sent_total_o    (sent_total_o)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import cep_pkg::*;

  // command code the block must ignore
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [TimeW-1:0]    now_ms;
    logic [IdW-1:0]      rx_id;
    logic [LenW-1:0]     rx_len;
    logic [PayloadW-1:0] rx_payload;
    logic [TimeW-1:0]    rtt_us;
    logic [BusErrW-1:0]  bus_err;
  } probe_txn_t;

  // tracks the probe link state and the reports it should produce
  class link_model;
    logic [TimeW-1:0]   tmo_limit;
    logic [MinCntW-1:0] min_count;
    logic [IdW-1:0]     tx_id;
    logic [IdW-1:0]     echo_id;
    logic [SeqW-1:0]    next_seq;
    logic [SeqW-1:0]    awaited_seq;
    logic               in_flight;
    logic [TimeW-1:0]   sent_ms;
    logic [CountW-1:0]  sent_n, echoed_n, corrupt_n, stale_n, timeout_n;
    logic [TimeW-1:0]   rtt_min, rtt_max;
    result_t            due_reports[$];
    int                 errors;
    int                 reports_checked;

    function new();
      tmo_limit = TIMEOUT_DEFAULT;
      min_count = MIN_COUNT_DEFAULT;
      tx_id = '0;
      echo_id = '0;
      next_seq = '0;
      awaited_seq = '0;
      in_flight = 1'b0;
      sent_ms = '0;
      sent_n = '0;
      echoed_n = '0;
      corrupt_n = '0;
      stale_n = '0;
      timeout_n = '0;
      rtt_min = '0;
      rtt_max = '0;
      errors = 0;
      reports_checked = 0;
    endfunction

    static function logic [PayloadW-1:0] pattern_of(logic [SeqW-1:0] seq);
      logic [7:0] fill;
      case (seq[1:0])
        2'd0:    fill = 8'h00;
        2'd1:    fill = 8'hFF;
        2'd2:    fill = 8'h55;
        default: fill = 8'hAA;
      endcase
      return {{6{fill}}, seq};
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TIMEOUT:  tmo_limit = (value == '0) ? TIMEOUT_DEFAULT : value;
        REG_MIN_CNT:  min_count = value[MinCntW-1:0];
        REG_TX_ID:    tx_id = value[IdW-1:0];
        REG_ECHO_ID:  echo_id = value[IdW-1:0];
        default: ;
      endcase
    endfunction

    function verdict_e judge(logic [BusErrW-1:0] bus_err);
      if (sent_n < {16'd0, min_count}) return VERDICT_RUNNING;
      if (echoed_n == '0 && corrupt_n == '0 && stale_n == '0) return VERDICT_SILENT;
      if (corrupt_n != '0) return VERDICT_CORRUPT;
      if (timeout_n != '0 || stale_n != '0) begin
        if (bus_err == '0) return VERDICT_DROPPED;
        return VERDICT_LOSSY;
      end
      return VERDICT_OK;
    endfunction

    // applies one accepted transaction, returns whether the block takes it up
    function bit take_command(probe_txn_t t);
      result_t         r;
      logic [TimeW-1:0] elapsed;
      r = '0;
      elapsed = t.now_ms - sent_ms;
      case (t.cmd)
        CMD_PROBE: begin
          if (!in_flight) begin
            r.accepted = 1'b1;
            r.probe_valid = 1'b1;
            r.probe_payload = pattern_of(next_seq);
            awaited_seq = next_seq;
            in_flight = 1'b1;
            sent_ms = t.now_ms;
            sent_n++;
            next_seq++;
          end
        end
        CMD_FRAME: begin
          if (t.rx_id == echo_id) begin
            r.accepted = 1'b1;
            if (t.rx_len != PROBE_LENGTH) begin
              corrupt_n++;
              in_flight = 1'b0;
            end else if (!in_flight || t.rx_payload[SeqW-1:0] != awaited_seq) begin
              stale_n++;
            end else begin
              if (t.rx_payload != pattern_of(awaited_seq)) begin
                corrupt_n++;
              end else begin
                echoed_n++;
                if (echoed_n == 32'd1 || t.rtt_us < rtt_min) rtt_min = t.rtt_us;
                if (t.rtt_us > rtt_max) rtt_max = t.rtt_us;
              end
              in_flight = 1'b0;
            end
          end
        end
        CMD_TICK: begin
          if (in_flight && elapsed >= tmo_limit) begin
            in_flight = 1'b0;
            timeout_n++;
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      r.verdict = judge(t.bus_err);
      r.sent = sent_n;
      r.echoed = echoed_n;
      r.corrupt = corrupt_n;
      r.stale = stale_n;
      r.timeouts = timeout_n;
      r.rtt_min = rtt_min;
      r.rtt_max = rtt_max;
      due_reports.push_back(r);
      return r.accepted;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void match_report(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        $error("result with no transaction waiting");
        errors++;
        return;
      end
      want = due_reports.pop_front();
      reports_checked++;
      compare("accepted", want.accepted, got.accepted);
      compare("probe_valid", want.probe_valid, got.probe_valid);
      compare("probe_payload", want.probe_payload, got.probe_payload);
      compare("verdict", want.verdict, got.verdict);
      compare("sent_total", want.sent, got.sent);
      compare("echoed_total", want.echoed, got.echoed);
      compare("corrupt_total", want.corrupt, got.corrupt);
      compare("stale_total", want.stale, got.stale);
      compare("timeout_total", want.timeouts, got.timeouts);
      compare("rtt_low_us", want.rtt_min, got.rtt_min);
      compare("rtt_high_us", want.rtt_max, got.rtt_max);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i = '0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic [IdW-1:0]      rx_identifier_i = '0;
  logic [LenW-1:0]     rx_length_i = '0;
  logic [PayloadW-1:0] rx_payload_i = '0;
  logic [TimeW-1:0]    round_trip_us_i = '0;
  logic [BusErrW-1:0]  bus_error_count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                accepted_o;
  logic                probe_valid_o;
  logic [PayloadW-1:0] probe_payload_o;
  logic [VerdictW-1:0] verdict_o;
  logic [CountW-1:0]   sent_total_o;
  logic [CountW-1:0]   echoed_total_o;
  logic [CountW-1:0]   corrupt_total_o;
  logic [CountW-1:0]   stale_total_o;
  logic [CountW-1:0]   timeout_total_o;
  logic [TimeW-1:0]    rtt_low_us_o;
  logic [TimeW-1:0]    rtt_high_us_o;

  link_model model;
  bit        calm = 1'b0;
  int        items_driven = 0;
  int        engaged = 0;
  result_t   seen_report;

  can_echo_probe_checker dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_report.accepted = accepted_o;
      seen_report.probe_valid = probe_valid_o;
      seen_report.probe_payload = probe_payload_o;
      seen_report.verdict = verdict_e'(verdict_o);
      seen_report.sent = sent_total_o;
      seen_report.echoed = echoed_total_o;
      seen_report.corrupt = corrupt_total_o;
      seen_report.stale = stale_total_o;
      seen_report.timeouts = timeout_total_o;
      seen_report.rtt_min = rtt_low_us_o;
      seen_report.rtt_max = rtt_high_us_o;
      model.match_report(seen_report);
    end
  end

  function automatic probe_txn_t mk(logic [CmdW-1:0] cmd, logic [TimeW-1:0] now,
                                    logic [IdW-1:0] id, logic [LenW-1:0] len,
                                    logic [PayloadW-1:0] pay, logic [TimeW-1:0] rtt,
                                    logic [BusErrW-1:0] err);
    probe_txn_t t;
    t.cmd = cmd;
    t.now_ms = now;
    t.rx_id = id;
    t.rx_len = len;
    t.rx_payload = pay;
    t.rtt_us = rtt;
    t.bus_err = err;
    return t;
  endfunction

  // mostly probe/echo exchanges, with broken frames, ticks and noise mixed in
  function automatic probe_txn_t roll_item();
    probe_txn_t      t;
    int              pick;
    logic [SeqW-1:0] seq;
    t.cmd = CMD_UNUSED;
    t.now_ms = $urandom;
    t.rx_id = IdW'($urandom);
    t.rx_len = LenW'($urandom);
    t.rx_payload = {$urandom, $urandom};
    t.rtt_us = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000);
    t.bus_err = ($urandom_range(0, 3) == 0) ? '0 : BusErrW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      t.cmd = CMD_PROBE;
    end else if (pick < 83) begin
      t.cmd = CMD_FRAME;
      t.rx_id = model.echo_id;
      t.rx_len = PROBE_LENGTH;
      seq = model.awaited_seq;
      t.rx_payload = link_model::pattern_of(seq);
      if (pick >= 63 && pick < 70) begin
        t.rx_payload[63:16] ^= 48'd1 << $urandom_range(0, 47);
      end else if (pick >= 70 && pick < 75) begin
        t.rx_len = LenW'($urandom_range(0, 14));
        if (t.rx_len == PROBE_LENGTH) t.rx_len = 4'd15;
      end else if (pick >= 75 && pick < 79) begin
        t.rx_payload = link_model::pattern_of(seq + SeqW'($urandom_range(1, 65535)));
      end else if (pick >= 79) begin
        t.rx_id = model.echo_id ^ IdW'($urandom_range(1, 29'h1FFF_FFFF));
      end
    end else if (pick < 97) begin
      t.cmd = CMD_TICK;
      case ($urandom_range(0, 3))
        0: t.now_ms = model.sent_ms + model.tmo_limit - 32'd1;
        1: t.now_ms = model.sent_ms + model.tmo_limit;
        2: t.now_ms = model.sent_ms + model.tmo_limit + $urandom_range(1, 100);
        default: ;
      endcase
    end
    return t;
  endfunction

  task automatic put_item(input probe_txn_t t);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= t.cmd;
    now_ms_i <= t.now_ms;
    rx_identifier_i <= t.rx_id;
    rx_length_i <= t.rx_len;
    rx_payload_i <= t.rx_payload;
    round_trip_us_i <= t.rtt_us;
    bus_error_count_i <= t.bus_err;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_driven++;
    if (model.take_command(t)) engaged++;
  endtask

  // hold the input channel until every report has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (model.due_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    model.set_reg(idx, value);
  endtask

  task automatic program_regs(input logic [31:0] tmo, input logic [15:0] minc,
                              input logic [28:0] pid, input logic [28:0] eid);
    settle();
    reg_write(REG_TIMEOUT, tmo);
    reg_write(REG_MIN_CNT, {16'd0, minc});
    reg_write(REG_TX_ID, {3'd0, pid});
    reg_write(REG_ECHO_ID, {3'd0, eid});
  endtask

  task automatic random_phase(input int target);
    int start_count;
    start_count = items_driven;
    while (items_driven - start_count < target) put_item(roll_item());
  endtask

  initial begin
    model = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle corner cases first, then a short exchange history
    put_item(mk(CMD_UNUSED, '1, '1, '1, '1, '1, '1));
    put_item(mk(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd8, link_model::pattern_of(16'd0), 32'd5, 16'd1));
    put_item(mk(CMD_FRAME, '0, 29'h1FFF_FFFF, 4'd8, link_model::pattern_of(16'd0), '0, '0));
    put_item(mk(CMD_PROBE, 32'hFFFF_FFF0, '0, '0, '0, '0, '0));
    put_item(mk(CMD_PROBE, 32'd3, '0, '0, '0, '0, '0));
    // elapsed time wraps through zero: one short, then exactly at the limit
    put_item(mk(CMD_TICK, 32'd33, '0, '0, '0, '0, '0));
    put_item(mk(CMD_TICK, 32'd34, '0, '0, '0, '0, 16'hFFFF));
    put_item(mk(CMD_PROBE, 32'd5, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd8, link_model::pattern_of(16'd2), '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd8,
                link_model::pattern_of(16'd1) ^ 64'hFF00_0000_0000_0000, '0, '0));
    put_item(mk(CMD_PROBE, 32'd6, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd8, link_model::pattern_of(16'd2), '1, '1));
    put_item(mk(CMD_PROBE, 32'd7, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd8, link_model::pattern_of(16'd3), '0, '0));
    put_item(mk(CMD_PROBE, 32'd8, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, '0, 4'd15, link_model::pattern_of(16'd4), '0, '0));

    program_regs(32'hFFFF_FFFF, 16'd0, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
    put_item(mk(CMD_PROBE, 32'd100, '0, '0, '0, '0, '0));
    put_item(mk(CMD_TICK, 32'd98, '0, '0, '0, '0, '0));
    put_item(mk(CMD_TICK, 32'd99, '0, '0, '0, '0, '0));
    put_item(mk(CMD_FRAME, '0, 29'h1FFF_FFFF, 4'd8, link_model::pattern_of(16'd5), '0, '0));

    // a zero timeout falls back to the default
    settle();
    reg_write(REG_TIMEOUT, 32'd0);
    put_item(mk(CMD_PROBE, '0, '0, '0, '0, '0, '0));
    put_item(mk(CMD_TICK, 32'd49, '0, '0, '0, '0, '0));
    put_item(mk(CMD_TICK, 32'd50, '0, '0, '0, '0, '0));

    program_regs(32'd1, 16'd0, 29'($urandom), 29'($urandom));
    random_phase(190);
    program_regs(32'hFFFF_FFFF, 16'hFFFF, '0, '0);
    calm = 1'b1;
    random_phase(190);
    calm = 1'b0;
    program_regs($urandom_range(2, 500), 16'($urandom_range(0, 30)),
                 29'h1FFF_FFFF, 29'h1FFF_FFFF);
    random_phase(190);
    program_regs($urandom, 16'd3, 29'($urandom), 29'($urandom));
    random_phase(190);

    settle();
    repeat (8) @(posedge clk_i);
    $display("drove %0d transactions (%0d taken up by the block), checked %0d results",
             items_driven, engaged, model.reports_checked);
    $display("probes %0d, echoes %0d, corrupt %0d, stale %0d, timeouts %0d",
             model.sent_n, model.echoed_n, model.corrupt_n, model.stale_n, model.timeout_n);
    if (model.errors == 0 && model.due_reports.size() == 0) begin
      $display("can_echo_probe_checker test passed");
    end else begin
      $display("can_echo_probe_checker test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("can_echo_probe_checker test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/cep_pkg.sv
rtl/core/cep_cfg.sv
rtl/core/cep_front.sv
rtl/core/cep_queue.sv
rtl/core/cep_back.sv
rtl/core/can_echo_probe_checker.sv
rtl/core/cep_checker.sv
test/tb_top.sv
